@@ rtl/ute_pkg.sv @@
// Shared types, constants and codes for the unsorted table engine.
package ute_pkg;

    localparam int CAPACITY = 64;
    localparam int ITEM_W   = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic [2:0] OP_INSERT   = 3'd0;
    localparam logic [2:0] OP_DELETE   = 3'd1;
    localparam logic [2:0] OP_RETRIEVE = 3'd2;
    localparam logic [2:0] OP_CLEAR    = 3'd3;
    localparam logic [2:0] OP_REWIND   = 3'd4;
    localparam logic [2:0] OP_NEXT     = 3'd5;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_PAST_END  = 2'd3;

    typedef struct packed {
        logic [2:0]        mode;
        logic [ITEM_W-1:0] item;
    } t_in;

    typedef struct packed {
        logic [ITEM_W-1:0] item_out;
        logic              found;
        logic [1:0]        status;
        logic [CNT_W-1:0]  count;
        logic              full_res;
        logic              empty_res;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_DEL_RD,
        S_DEL_WR,
        S_NXT_CAP,
        S_RESULT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic ins;
        logic clr;
        logic rewind;
        logic nxt_rd;
        logic nxt_cap;
        logic scan;
        logic rd_last;
        logic del_wr;
        logic emit;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [2:0] op;
        logic       hit;
        logic       miss;
        logic       cur_ok;
    } t_sts;

endpackage

@@ rtl/ute_ctrl.sv @@
// Sequencing state machine for the unsorted table engine.
module ute_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  ute_pkg::t_sts i_sts,
    output ute_pkg::t_cmd o_cmd
);
    import ute_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                if (i_sts.op == OP_DELETE || i_sts.op == OP_RETRIEVE) begin
                    n_state = S_SCAN;
                end else if (i_sts.op == OP_NEXT && i_sts.cur_ok) begin
                    n_state = S_NXT_CAP;
                end else begin
                    n_state = S_RESULT;
                end
            end
            S_SCAN: begin
                if (i_sts.hit) begin
                    n_state = (i_sts.op == OP_DELETE) ? S_DEL_RD : S_RESULT;
                end else if (i_sts.miss) begin
                    n_state = S_RESULT;
                end
            end
            S_DEL_RD:  n_state = S_DEL_WR;
            S_DEL_WR:  n_state = S_RESULT;
            S_NXT_CAP: n_state = S_RESULT;
            S_RESULT:  n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE:     o_cmd.load = start;
            S_DISPATCH: begin
                o_cmd.ins    = (i_sts.op == OP_INSERT);
                o_cmd.clr    = (i_sts.op == OP_CLEAR);
                o_cmd.rewind = (i_sts.op == OP_REWIND);
                o_cmd.nxt_rd = (i_sts.op == OP_NEXT);
            end
            S_SCAN:     o_cmd.scan    = 1'b1;
            S_DEL_RD:   o_cmd.rd_last = 1'b1;
            S_DEL_WR:   o_cmd.del_wr  = 1'b1;
            S_NXT_CAP:  o_cmd.nxt_cap = 1'b1;
            S_RESULT:   o_cmd.emit    = 1'b1;
            default:    o_cmd = '0;
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule

@@ rtl/ute_dp.sv @@
// Table storage, counters, scan compare and result register.
module ute_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ute_pkg::t_in  i_cmd_in,
    input  ute_pkg::t_cmd i_cmd,
    output ute_pkg::t_sts o_sts,
    output logic          o_valid,
    output ute_pkg::t_out o_res
);
    import ute_pkg::*;

    logic [ITEM_W-1:0] mem [CAPACITY];

    logic [2:0]        r_op;
    logic [ITEM_W-1:0] r_key;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_cursor;
    logic [CNT_W-1:0]  r_idx;
    logic [IDX_W-1:0]  r_raddr;
    logic              r_rvalid;
    logic [IDX_W-1:0]  r_loc;
    logic [ITEM_W-1:0] r_rdata;
    logic [ITEM_W-1:0] r_iout;
    logic              r_found;
    logic [1:0]        r_status;
    logic              r_valid;
    t_out              r_res;

    logic              full;
    logic              hit;
    logic              miss;
    logic              cur_ok;
    logic [CNT_W-1:0]  last;
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [ITEM_W-1:0] wdata;
    logic              re;
    logic [IDX_W-1:0]  raddr;
    logic              scan_rd;

    assign full    = (r_count == CNT_W'(CAPACITY));
    assign hit     = r_rvalid && (r_rdata == r_key);
    assign scan_rd = (r_idx < r_count);
    assign miss    = !hit && !scan_rd;
    assign cur_ok  = (r_cursor < r_count);
    assign last    = r_count - CNT_W'(1);

    assign o_sts.op     = r_op;
    assign o_sts.hit    = hit;
    assign o_sts.miss   = miss;
    assign o_sts.cur_ok = cur_ok;

    // single write port: append on insert, slot fill on delete
    always_comb begin
        we    = 1'b0;
        waddr = r_count[IDX_W-1:0];
        wdata = r_key;
        if (i_cmd.ins && !full) begin
            we = 1'b1;
        end else if (i_cmd.del_wr) begin
            we    = 1'b1;
            waddr = r_loc;
            wdata = r_rdata;
        end
    end

    always_comb begin
        re    = 1'b0;
        raddr = r_idx[IDX_W-1:0];
        if (i_cmd.scan && !hit && scan_rd) begin
            re = 1'b1;
        end else if (i_cmd.rd_last) begin
            re    = 1'b1;
            raddr = last[IDX_W-1:0];
        end else if (i_cmd.nxt_rd && cur_ok) begin
            re    = 1'b1;
            raddr = r_cursor[IDX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) mem[waddr] <= wdata;
        if (re) r_rdata <= mem[raddr];
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_cmd_in.mode;
            r_key    <= i_cmd_in.item;
            r_iout   <= '0;
            r_found  <= 1'b0;
            r_status <= ST_OK;
        end
        if (i_cmd.ins && full) r_status <= ST_FULL;
        if (i_cmd.nxt_rd && !cur_ok) r_status <= ST_PAST_END;
        if (i_cmd.nxt_cap) r_iout <= r_rdata;
        if (i_cmd.scan) begin
            if (hit) begin
                r_loc   <= r_raddr;
                r_found <= 1'b1;
                if (r_op == OP_RETRIEVE) r_iout <= r_rdata;
            end else if (miss) begin
                r_status <= ST_NOT_FOUND;
            end else begin
                r_raddr <= r_idx[IDX_W-1:0];
            end
        end
        if (i_cmd.emit) begin
            r_res.item_out  <= r_iout;
            r_res.found     <= r_found;
            r_res.status    <= r_status;
            r_res.count     <= r_count;
            r_res.full_res  <= full;
            r_res.empty_res <= (r_count == '0);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_cursor <= '0;
            r_idx    <= '0;
            r_rvalid <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
            if (i_cmd.load) begin
                r_idx    <= '0;
                r_rvalid <= 1'b0;
            end
            if (i_cmd.ins && !full) r_count <= r_count + CNT_W'(1);
            if (i_cmd.clr) r_count <= '0;
            if (i_cmd.del_wr) r_count <= last;
            if (i_cmd.rewind) r_cursor <= '0;
            if (i_cmd.nxt_rd && cur_ok) r_cursor <= r_cursor + CNT_W'(1);
            if (i_cmd.scan && !hit && scan_rd) begin
                r_idx    <= r_idx + CNT_W'(1);
                r_rvalid <= 1'b1;
            end else if (i_cmd.scan) begin
                r_rvalid <= 1'b0;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

@@ rtl/unsorted_table_engine.sv @@
// Top level of the unsorted table engine: controller plus datapath.
//
// A command word (mode, item) is taken on a clock edge where start is high
// and busy is low. Exactly one result word follows, shown on o_res for one
// cycle with o_valid high; the receiver must take it then, it cannot stall.
// busy is high from the cycle after acceptance until the result shows, so
// a new command may be issued in the same cycle o_valid is high.
// Steps after acceptance, by mode:
//   insert, clear, rewind, unused modes : dispatch, then result
//   next     : dispatch with table read, capture, result (no read past the end)
//   retrieve : dispatch, scan from slot 0 to a hit or past the count, result
//   delete   : as retrieve; a hit reads the last entry into the hit slot
// The search reads the 64-entry table through its single read port, one
// entry per cycle, so delete and retrieve take longer the later the match lies.
// Synchronous active-low reset empties the table (count zero) and rewinds
// the cursor; table contents are not cleared and no clearing pass is needed.
module unsorted_table_engine (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         start,
    output logic         busy,
    input  ute_pkg::t_in i_cmd,
    output logic         o_valid,
    output ute_pkg::t_out o_res
);
    import ute_pkg::*;

    t_cmd cmd;
    t_sts sts;

    ute_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    ute_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd_in (i_cmd),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .o_valid  (o_valid),
        .o_res    (o_res)
    );

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking bench for the unsorted table engine: directed rows, then random episodes.
module tb_top;
    import ute_pkg::*;

    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;
    localparam int RUN_ITEMS   = 1200;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 100;

    logic  i_clk   = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  start   = 1'b0;
    t_in   i_cmd   = '0;
    logic  busy;
    logic  o_valid;
    t_out  o_res;

    always #5 i_clk = ~i_clk;

    unsorted_table_engine u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_cmd   (i_cmd),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

    typedef struct {
        t_in  cmd;
        bit   typed;
        t_out want;
    } t_row;

    t_out              pending_results[$];
    t_row              plan[$];
    logic [ITEM_W-1:0] shadow_words[CAPACITY];
    int                shadow_count;
    int                shadow_cursor;
    logic [ITEM_W-1:0] word_pool[16];
    int                err_count;
    int                cycle_count;
    int                items_sent;
    int                burst_left;
    t_out              oldest;

    task automatic log_mismatch(string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        err_count++;
    endtask

    task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            log_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    // Table shadow: applies one command and returns the word the block should report.
    function automatic t_out predict_outcome(t_in c);
        t_out r;
        int   loc;
        r   = '0;
        loc = shadow_count;
        // lowest-indexed match wins
        for (int i = shadow_count - 1; i >= 0; i--)
            if (shadow_words[i] == c.item)
                loc = i;
        case (c.mode)
            OP_INSERT: begin
                if (shadow_count >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    shadow_words[shadow_count] = c.item;
                    shadow_count++;
                end
            end
            OP_DELETE: begin
                if (loc < shadow_count) begin
                    shadow_words[loc] = shadow_words[shadow_count - 1];
                    shadow_count--;
                    r.found = 1'b1;
                end else begin
                    r.status = ST_NOT_FOUND;
                end
            end
            OP_RETRIEVE: begin
                if (loc < shadow_count) begin
                    r.item_out = shadow_words[loc];
                    r.found    = 1'b1;
                end else begin
                    r.status = ST_NOT_FOUND;
                end
            end
            OP_CLEAR:  shadow_count = 0;
            OP_REWIND: shadow_cursor = 0;
            OP_NEXT: begin
                if (shadow_cursor < shadow_count) begin
                    r.item_out = shadow_words[shadow_cursor];
                    shadow_cursor++;
                end else begin
                    r.status = ST_PAST_END;
                end
            end
            default: ;
        endcase
        r.count     = CNT_W'(shadow_count);
        r.full_res  = (shadow_count == CAPACITY);
        r.empty_res = (shadow_count == 0);
        return r;
    endfunction

    function automatic t_out make_result(logic [ITEM_W-1:0] item_out, logic found,
                                         logic [1:0] status, int cnt);
        t_out r;
        r.item_out  = item_out;
        r.found     = found;
        r.status    = status;
        r.count     = CNT_W'(cnt);
        r.full_res  = (cnt == CAPACITY);
        r.empty_res = (cnt == 0);
        return r;
    endfunction

    task automatic add_row(logic [2:0] mode, logic [ITEM_W-1:0] item);
        t_row row;
        row.cmd.mode = mode;
        row.cmd.item = item;
        row.typed    = 1'b0;
        row.want     = '0;
        plan.push_back(row);
    endtask

    task automatic add_typed(logic [2:0] mode, logic [ITEM_W-1:0] item, t_out want);
        t_row row;
        row.cmd.mode = mode;
        row.cmd.item = item;
        row.typed    = 1'b1;
        row.want     = want;
        plan.push_back(row);
    endtask

    // Bursty sender: holds start until the word is taken, then books the expected result.
    task automatic send(t_in c, bit typed, t_out want);
        int   gap;
        t_out predicted;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy);
        predicted = predict_outcome(c);
        pending_results.push_back(typed ? want : predicted);
        if (c.mode != OP_SPARE_6 && c.mode != OP_SPARE_7)
            items_sent++;
    endtask

    task automatic issue(logic [2:0] mode, logic [ITEM_W-1:0] item);
        t_in c;
        c.mode = mode;
        c.item = item;
        send(c, 1'b0, '0);
    endtask

    task automatic drain_wait();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        burst_left = 0;
    endtask

    function automatic logic [ITEM_W-1:0] pick_word();
        if ($urandom_range(0, 9) < 7)
            return word_pool[$urandom_range(0, 15)];
        return $urandom;
    endfunction

    function automatic logic [ITEM_W-1:0] present_word();
        if (shadow_count > 0)
            return shadow_words[$urandom_range(0, shadow_count - 1)];
        return pick_word();
    endfunction

    task automatic fill_episode();
        while (shadow_count < CAPACITY) begin
            if ($urandom_range(0, 7) == 0)
                issue(OP_RETRIEVE, present_word());
            else
                issue(OP_INSERT, pick_word());
        end
        repeat ($urandom_range(1, 3)) issue(OP_INSERT, pick_word());
        issue(OP_RETRIEVE, $urandom);
        issue(OP_RETRIEVE, shadow_words[CAPACITY - 1]);
    endtask

    task automatic drain_episode();
        while (shadow_count > 0) begin
            if ($urandom_range(0, 5) == 0)
                issue(OP_DELETE, $urandom);
            else
                issue(OP_DELETE, present_word());
            if ($urandom_range(0, 9) == 0)
                issue(OP_NEXT, $urandom);
        end
        issue(OP_DELETE, pick_word());
    endtask

    task automatic walk_episode();
        issue(OP_REWIND, $urandom);
        repeat (shadow_count + $urandom_range(1, 3)) issue(OP_NEXT, $urandom);
    endtask

    task automatic churn_episode();
        int pick;
        repeat ($urandom_range(20, 40)) begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
                issue(OP_INSERT, pick_word());
            else if (pick < 50)
                issue(OP_DELETE, $urandom_range(0, 3) == 0 ? pick_word() : present_word());
            else if (pick < 70)
                issue(OP_RETRIEVE, $urandom_range(0, 3) == 0 ? pick_word() : present_word());
            else if (pick < 72)
                issue(OP_CLEAR, $urandom);
            else if (pick < 76)
                issue(OP_REWIND, $urandom);
            else if (pick < 92)
                issue(OP_NEXT, $urandom);
            else if (pick < 96)
                issue(OP_SPARE_6, $urandom);
            else
                issue(OP_SPARE_7, $urandom);
        end
    endtask

    // Result checker: every strobed word must match the oldest booked expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                log_mismatch("result word with nothing pending");
            end else begin
                oldest = pending_results.pop_front();
                compare_field("item_out", 32'(o_res.item_out), 32'(oldest.item_out));
                compare_field("found", 32'(o_res.found), 32'(oldest.found));
                compare_field("status", 32'(o_res.status), 32'(oldest.status));
                compare_field("count", 32'(o_res.count), 32'(oldest.count));
                compare_field("full_res", 32'(o_res.full_res), 32'(oldest.full_res));
                compare_field("empty_res", 32'(o_res.empty_res), 32'(oldest.empty_res));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    initial begin
        err_count     = 0;
        cycle_count   = 0;
        items_sent    = 0;
        burst_left    = 0;
        shadow_count  = 0;
        shadow_cursor = 0;
        word_pool[0]  = '0;
        word_pool[1]  = '1;
        for (int i = 2; i < 16; i++)
            word_pool[i] = $urandom;

        add_typed(OP_NEXT,     32'h0,         make_result('0, 1'b0, ST_PAST_END, 0));
        add_typed(OP_DELETE,   32'hFFFF_FFFF, make_result('0, 1'b0, ST_NOT_FOUND, 0));
        add_typed(OP_RETRIEVE, 32'h0,         make_result('0, 1'b0, ST_NOT_FOUND, 0));
        add_typed(OP_CLEAR,    32'h0,         make_result('0, 1'b0, ST_OK, 0));
        add_typed(OP_INSERT,   32'h0,         make_result('0, 1'b0, ST_OK, 1));
        add_typed(OP_INSERT,   32'hFFFF_FFFF, make_result('0, 1'b0, ST_OK, 2));
        add_typed(OP_INSERT,   32'h5A5A_A5A5, make_result('0, 1'b0, ST_OK, 3));
        add_typed(OP_INSERT,   32'h0,         make_result('0, 1'b0, ST_OK, 4));
        add_typed(OP_RETRIEVE, 32'hFFFF_FFFF, make_result(32'hFFFF_FFFF, 1'b1, ST_OK, 4));
        add_typed(OP_RETRIEVE, 32'h0,         make_result('0, 1'b1, ST_OK, 4));
        add_typed(OP_RETRIEVE, 32'h1234_5678, make_result('0, 1'b0, ST_NOT_FOUND, 4));
        add_typed(OP_NEXT,     32'hFFFF_FFFF, make_result('0, 1'b0, ST_OK, 4));
        add_typed(OP_NEXT,     32'h0,         make_result(32'hFFFF_FFFF, 1'b0, ST_OK, 4));
        // duplicate: the first copy goes, the last entry moves into slot 0
        add_row(OP_DELETE, 32'h0);
        add_row(OP_NEXT, 32'h0);
        add_typed(OP_NEXT,     32'h0,         make_result('0, 1'b0, ST_PAST_END, 3));
        add_typed(OP_REWIND,   32'hFFFF_FFFF, make_result('0, 1'b0, ST_OK, 3));
        add_row(OP_NEXT, 32'h0);
        add_typed(OP_SPARE_6,  32'hFFFF_FFFF, make_result('0, 1'b0, ST_OK, 3));
        add_typed(OP_SPARE_7,  32'h0,         make_result('0, 1'b0, ST_OK, 3));
        add_typed(OP_DELETE,   32'h1234_5678, make_result('0, 1'b0, ST_NOT_FOUND, 3));
        add_typed(OP_CLEAR,    32'hFFFF_FFFF, make_result('0, 1'b0, ST_OK, 0));
        // cursor left beyond the cleared count
        add_typed(OP_NEXT,     32'h0,         make_result('0, 1'b0, ST_PAST_END, 0));
        add_row(OP_INSERT, 32'hA5A5_5A5A);
        add_row(OP_NEXT, 32'h0);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i])
            send(plan[i].cmd, plan[i].typed, plan[i].want);
        drain_wait();

        fill_episode();
        while (items_sent < RUN_ITEMS) begin
            case ($urandom_range(0, 4))
                0:       fill_episode();
                1:       drain_episode();
                2:       walk_episode();
                default: churn_episode();
            endcase
            if ($urandom_range(0, 3) == 0)
                drain_wait();
        end

        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (err_count == 0 && pending_results.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

@@ unsorted_table_engine.f @@
rtl/ute_pkg.sv
rtl/ute_ctrl.sv
rtl/ute_dp.sv
rtl/unsorted_table_engine.sv
bench/tb_top.sv
